### rtl/assert_macros.svh
// assertion helpers, clocked on clock and disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSTM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define MSTM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/mstm_pkg.sv
`default_nettype none

package mstm_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int TIME_W         = 32;
   localparam int SLOT_FIELD_W   = 4;
   localparam int FUNC_W         = 2;
   localparam int STATUS_W       = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_TICK    = 2'd0,
      FN_SET     = 2'd1,
      FN_QUERY   = 2'd2,
      FN_RELEASE = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK      = 2'd0,
      RS_PASSED  = 2'd1,
      RS_INVALID = 2'd2,
      RS_REFUSED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // take the accepted word
      logic scan;    // issue one slot read and step the slot counter
      logic finish;  // write back and load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_lookup;  // incoming word is a query or a release
      logic scan_last;   // slot counter sits on the last slot
      logic pipe_busy;   // slot reads still in flight
      logic out_free;    // result register can take a new word
   } dp_sts_type;

endpackage

`default_nettype wire

### rtl/mstm_ctrl.sv
`default_nettype none

module mstm_ctrl
   import mstm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire dp_sts_type   sts,
   output ctrl_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // no word is taken while reset is high
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = sts.req_lookup ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/mstm_dp.sv
`default_nettype none

module mstm_dp
   import mstm_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_cmd_type            cmd,
   output dp_sts_type                   sts,
   input  wire logic [FUNC_W-1:0]       req_func,
   input  wire logic [TIME_W-1:0]       req_duration,
   input  wire logic [SLOT_FIELD_W-1:0] req_slot,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [SLOT_FIELD_W-1:0]      rsp_slot_out,
   output logic [TIME_W-1:0]            rsp_next_delay
);

   `include "assert_macros.svh"

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CMP_W = ((IDX_W > SLOT_FIELD_W) ? IDX_W : SLOT_FIELD_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // item context
   logic [TIME_W-1:0] time_ff;
   func_type          op_ff;
   logic [TIME_W-1:0] dur_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              slot_ok_ff;

   // slot state
   logic [TIME_W-1:0]     dl_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] used_ff;
   logic [SLOT_COUNT-1:0] armed_ff;
   logic [SLOT_COUNT-1:0] passed_ff;

   // read stage
   logic              a_vld_ff;
   logic [IDX_W-1:0]  a_idx_ff;
   logic              a_pend_ff;
   logic              a_free_ff;
   logic [TIME_W-1:0] a_dl_ff;

   // difference stage
   logic              b_vld_ff;
   logic [IDX_W-1:0]  b_idx_ff;
   logic              b_pend_ff;
   logic              b_free_ff;
   logic [TIME_W-1:0] b_left_ff;

   // scan results
   logic [TIME_W-1:0] mn_ff;
   logic              fnd_ff;
   logic [IDX_W-1:0]  fidx_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [TIME_W-1:0]       rsp_delay_ff;

   func_type          req_op;
   logic              req_lookup;
   logic              req_in_range;
   logic              left_lt;
   logic              left_pos;
   logic              set_ok;
   logic              expire;
   status_type        look_status;
   logic [TIME_W-1:0] tick_delay;

   assign req_op       = func_type'(req_func);
   assign req_lookup   = (req_op == FN_QUERY) || (req_op == FN_RELEASE);
   assign req_in_range = CMP_W'(req_slot) < CMP_W'(SLOT_COUNT);

   assign left_lt  = b_left_ff < mn_ff;
   assign left_pos = !b_left_ff[TIME_W-1] && (b_left_ff != '0);
   assign expire   = b_vld_ff && (op_ff == FN_TICK) && b_pend_ff && !left_pos;
   assign set_ok   = (dur_ff != '0) && fnd_ff;
   // all ones cannot be a positive signed distance, so it marks nothing pending
   assign tick_delay = (&mn_ff) ? '0 : mn_ff;

   always_comb begin
      if (!slot_ok_ff || !used_ff[idx_ff] || !armed_ff[idx_ff]) begin
         look_status = RS_INVALID;
      end else if (passed_ff[idx_ff]) begin
         look_status = RS_PASSED;
      end else begin
         look_status = RS_OK;
      end
   end

   assign sts.req_lookup = req_lookup;
   assign sts.scan_last  = (idx_ff == LAST_IDX);
   assign sts.pipe_busy  = a_vld_ff || b_vld_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   // context and scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (cmd.load && (req_op == FN_TICK)) begin
         time_ff <= time_ff + TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_op;
         dur_ff     <= req_duration;
         slot_ok_ff <= req_in_range;
         idx_ff     <= (req_lookup && req_in_range) ? IDX_W'(req_slot) : '0;
      end else if (cmd.scan && !sts.scan_last) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // deadline store, one read and one write port
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         a_dl_ff <= dl_mem[idx_ff];
      end
      if (cmd.finish && (op_ff == FN_SET) && set_ok) begin
         dl_mem[fidx_ff] <= time_ff + dur_ff;
      end
   end

   // slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         armed_ff  <= '0;
         passed_ff <= '0;
      end else if (cmd.finish) begin
         if ((op_ff == FN_SET) && set_ok) begin
            used_ff[fidx_ff]   <= 1'b1;
            armed_ff[fidx_ff]  <= 1'b1;
            passed_ff[fidx_ff] <= 1'b0;
         end else if ((op_ff == FN_RELEASE) && slot_ok_ff) begin
            used_ff[idx_ff]  <= 1'b0;
            armed_ff[idx_ff] <= 1'b0;
         end
      end else if (expire) begin
         passed_ff[b_idx_ff] <= 1'b1;
      end
   end

   // scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= cmd.scan;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff  <= idx_ff;
      a_pend_ff <= used_ff[idx_ff] && armed_ff[idx_ff] && !passed_ff[idx_ff];
      a_free_ff <= !used_ff[idx_ff];
      b_idx_ff  <= a_idx_ff;
      b_pend_ff <= a_pend_ff;
      b_free_ff <= a_free_ff;
      b_left_ff <= a_dl_ff - time_ff;
   end

   // running minimum and first free slot
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mn_ff  <= (req_op == FN_TICK) ? '1 : req_duration;
         fnd_ff <= 1'b0;
      end else if (b_vld_ff) begin
         if (op_ff == FN_TICK) begin
            if (b_pend_ff && left_pos && left_lt) begin
               mn_ff <= b_left_ff;
            end
         end else begin
            if (b_pend_ff && !b_left_ff[TIME_W-1] && left_lt) begin
               mn_ff <= b_left_ff;
            end
            if (b_free_ff && !fnd_ff) begin
               fnd_ff  <= 1'b1;
               fidx_ff <= b_idx_ff;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         case (op_ff)
            FN_TICK: begin
               rsp_status_ff <= RS_OK;
               rsp_slot_ff   <= '0;
               rsp_delay_ff  <= tick_delay;
            end
            FN_SET: begin
               rsp_status_ff <= set_ok ? RS_OK : RS_REFUSED;
               rsp_slot_ff   <= set_ok ? SLOT_FIELD_W'(fidx_ff) : '0;
               rsp_delay_ff  <= set_ok ? mn_ff : '0;
            end
            default: begin
               rsp_status_ff <= look_status;
               rsp_slot_ff   <= '0;
               rsp_delay_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_next_delay = rsp_delay_ff;

   `MSTM_ASSERT_IMP(a_no_finish_in_scan, a_vld_ff || b_vld_ff, !cmd.finish && !cmd.load)
   `MSTM_ASSERT_NXT(a_finish_shows_word, cmd.finish, rsp_valid_ff)
   `MSTM_ASSERT_NXT(a_set_claims_slot, cmd.finish && (op_ff == FN_SET) && set_ok,
      used_ff[$past(fidx_ff)] && armed_ff[$past(fidx_ff)] && !passed_ff[$past(fidx_ff)])
   `MSTM_ASSERT_NXT(a_time_only_on_tick, !(cmd.load && (req_op == FN_TICK)), $stable(time_ff))
   `MSTM_ASSERT_NXT(a_expire_marks_passed, expire, passed_ff[$past(b_idx_ff)])

endmodule

`default_nettype wire

### rtl/multi_slot_timeout_manager.sv
`default_nettype none
// channel   dir  tdata bits  fields (lowest bit up)
// req_      in   40          func[1:0] duration[33:2] slot[37:34]
// rsp_      out  40          status[1:0] slot_out[5:2] next_delay[37:6]
//
// tick and set scan every slot through the one read port of the deadline store:
// each slot is read in turn, then the read and difference stages drain before write back
// query and release read the flags directly and go from accept straight to write back
// one word in progress at a time, a new one is taken once the last is registered
// synchronous reset zeroes time and slot flags, not deadlines; req_tready stays low
// rsp_tready low holds the result register and then the finished word behind it

module multi_slot_timeout_manager
   import mstm_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // func[1:0], duration[33:2], slot[37:34]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // status[1:0], slot_out[5:2], next_delay[37:6]
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   logic [STATUS_W-1:0]     rsp_status;
   logic [SLOT_FIELD_W-1:0] rsp_slot_out;
   logic [TIME_W-1:0]       rsp_next_delay;

   // sequencing: accept, slot scan, drain of the read pipe, write back
   mstm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // time counter, slot store, compare pipe and result register
   mstm_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_tdata[1:0]),
      .req_duration   (req_tdata[33:2]),
      .req_slot       (req_tdata[37:34]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_next_delay (rsp_next_delay)
   );

   // pack the result word, pad to whole bytes
   assign rsp_tdata = {2'b00, rsp_next_delay, rsp_slot_out, rsp_status};

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
   import mstm_pkg::*;

   localparam int SLOTS        = SLOT_COUNT_DEF;
   localparam int RANDOM_WORDS = 650;
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
   localparam int STALL_LIMIT  = 4000;   // cycles with no handshake on either side
   localparam int SETTLE       = SLOTS + 8;

   // req_tdata: func[1:0] duration[33:2] slot[37:34], zero padding above
   typedef struct packed {
      logic [1:0]  pad;
      logic [3:0]  slot;
      logic [31:0] duration;
      func_type    func;
   } req_word_type;

   // rsp_tdata: status[1:0] slot_out[5:2] next_delay[37:6], zero padding above
   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] next_delay;
      logic [3:0]  slot_out;
      status_type  status;
   } rsp_word_type;

   // timer pool mirror and queue of the results it owes
   class timeout_scoreboard;
      bit [31:0] now;
      bit [31:0] deadline [SLOTS];
      bit        used     [SLOTS];
      bit        armed    [SLOTS];
      bit        passed   [SLOTS];
      rsp_word_type owed [$];
      int        errors;
      int        func_seen   [4];
      int        status_seen [4];

      function int waiting();
         return owed.size();
      endfunction

      // advance the pool by one accepted request word
      function void note_request(req_word_type w);
         rsp_word_type res;
         logic [31:0] left;
         logic [31:0] best;
         bit have;
         int found;
         res = '0;
         res.status = RS_OK;
         best = '0;
         have = 1'b0;
         found = -1;
         func_seen[w.func]++;
         case (w.func)
            FN_TICK: begin
               now += 1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (used[i] && armed[i] && !passed[i]) begin
                     left = deadline[i] - now;
                     if ($signed(left) <= 0) begin
                        passed[i] = 1'b1;
                     end else if (!have || left < best) begin
                        best = left;
                        have = 1'b1;
                     end
                  end
               end
               res.next_delay = best;
            end
            FN_SET: begin
               if (w.duration == 0) begin
                  res.status = RS_REFUSED;
               end else begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (found < 0 && !used[i]) found = i;
                  end
                  if (found < 0) begin
                     res.status = RS_REFUSED;
                  end else begin
                     deadline[found] = now + w.duration;
                     used[found]   = 1'b1;
                     armed[found]  = 1'b1;
                     passed[found] = 1'b0;
                     // only deadlines not yet behind the clock can lower the delay
                     best = w.duration;
                     for (int i = 0; i < SLOTS; i++) begin
                        if (used[i] && armed[i] && !passed[i]) begin
                           left = deadline[i] - now;
                           if (!left[31] && left < best) best = left;
                        end
                     end
                     res.slot_out   = 4'(found);
                     res.next_delay = best;
                  end
               end
            end
            FN_QUERY, FN_RELEASE: begin
               if (int'(w.slot) >= SLOTS) begin
                  res.status = RS_INVALID;
               end else begin
                  if (!used[w.slot] || !armed[w.slot]) res.status = RS_INVALID;
                  else res.status = passed[w.slot] ? RS_PASSED : RS_OK;
                  // release keeps the passed flag
                  if (w.func == FN_RELEASE) begin
                     used[w.slot]  = 1'b0;
                     armed[w.slot] = 1'b0;
                  end
               end
            end
         endcase
         owed.push_back(res);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = owed.pop_front();
         status_seen[want.status]++;
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.slot_out !== want.slot_out) begin
            $display("%0t: slot_out mismatch, expected %0d actual %0d",
                     $time, want.slot_out, got.slot_out);
            errors++;
         end
         if (got.next_delay !== want.next_delay) begin
            $display("%0t: next_delay mismatch, expected %h actual %h",
                     $time, want.next_delay, got.next_delay);
            errors++;
         end
         if (got.pad !== want.pad) begin
            $display("%0t: padding mismatch, expected %b actual %b",
                     $time, want.pad, got.pad);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   timeout_scoreboard pool = new;

   bit calm;            // no idling on either side while set
   bit hold_off_req;    // asks the receiver for one long hold-off
   int stall_cycles;

   multi_slot_timeout_manager #(.SLOT_COUNT(SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one word and hold it until the block takes it
   task automatic offer(func_type f, logic [31:0] dur, logic [3:0] s);
      req_word_type w;
      w = '0;
      w.func = f;
      w.duration = dur;
      w.slot = s;
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      pool.note_request(w);
   endtask

   task automatic sender_gap();
      int n;
      if (!calm && $urandom_range(0, 99) < 25) begin
         n = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop offering until every owed result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pool.waiting() != 0);
   endtask

   // mostly aim query and release at slots in use
   function automatic logic [3:0] pick_slot();
      int live [$];
      for (int i = 0; i < SLOTS; i++) begin
         if (pool.used[i]) live.push_back(i);
      end
      if (live.size() > 0 && $urandom_range(0, 99) < 75)
         return 4'(live[$urandom_range(0, live.size() - 1)]);
      return 4'($urandom_range(0, 15));
   endfunction

   // short timeouts so ticks expire them; some zero, some huge or near the sign bit
   function automatic logic [31:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 68) return $urandom_range(1, 24);
      if (r < 76) return 32'd0;
      if (r < 88) return $urandom;
      return 32'h7FFF_FFF0 + $urandom_range(0, 31);
   endfunction

   // receiver: random backpressure, one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) pool.check_response(rsp_word_type'(rsp_tdata));
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, no word moved for %0d cycles", $time, stall_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      func_type f;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pool, zero duration, extreme durations, expiry,
      // query and release of passed and unused slots, full pool
      offer(FN_TICK,    32'd0,          4'd0);
      offer(FN_QUERY,   32'd0,          4'd0);
      offer(FN_SET,     32'd0,          4'd0);
      offer(FN_SET,     32'd1,          4'd0);
      offer(FN_SET,     32'hFFFF_FFFF,  4'd0);
      offer(FN_SET,     32'h8000_0000,  4'd0);
      offer(FN_QUERY,   32'hFFFF_FFFF,  4'd0);
      offer(FN_TICK,    32'hFFFF_FFFF,  4'hF);
      offer(FN_QUERY,   32'd0,          4'd0);
      offer(FN_RELEASE, 32'd0,          4'd0);
      offer(FN_QUERY,   32'd0,          4'd0);
      offer(FN_RELEASE, 32'd0,          4'd15);
      for (int k = 0; k < SLOTS - 2; k++) begin
         offer(FN_SET, (k == 5) ? 32'h7FFF_FFFF : 32'(k + 2), 4'($urandom_range(0, 15)));
      end
      offer(FN_SET,     32'd9,          4'd0);

      // random part
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 200) hold_off_req = 1'b1;
         if (n == 300) calm = 1'b1;
         if (n == 400) calm = 1'b0;
         if (n == 470) drain();
         else sender_gap();
         case ($urandom_range(0, 99)) inside
            [0:34]:  f = FN_TICK;
            [35:61]: f = FN_SET;
            [62:79]: f = FN_QUERY;
            default: f = FN_RELEASE;
         endcase
         if (f == FN_SET) offer(f, pick_duration(), 4'($urandom_range(0, 15)));
         else if (f == FN_TICK) offer(f, $urandom, 4'($urandom_range(0, 15)));
         else offer(f, $urandom, pick_slot());
      end

      drain();
      repeat (SETTLE) @(posedge clock);

      $display("words: %0d tick, %0d set, %0d query, %0d release",
               pool.func_seen[FN_TICK], pool.func_seen[FN_SET],
               pool.func_seen[FN_QUERY], pool.func_seen[FN_RELEASE]);
      $display("results: %0d ok, %0d passed, %0d invalid, %0d refused",
               pool.status_seen[RS_OK], pool.status_seen[RS_PASSED],
               pool.status_seen[RS_INVALID], pool.status_seen[RS_REFUSED]);
      if (pool.errors == 0 && pool.waiting() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
